// ----- rtl/expiring_work_timer_table_macros.svh -----
// assertion macros for the expiring work timer table checker
`ifndef EXPIRING_WORK_TIMER_TABLE_MACROS_SVH
`define EXPIRING_WORK_TIMER_TABLE_MACROS_SVH

// clocked assertion, off while reset is held
`define EWT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication checked in the next cycle, built on the one above
`define EWT_ASSERT_NEXT(lbl, ante, cons, msg) \
    `EWT_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- rtl/ewt_pkg.sv -----
// shared types and codes for the expiring work timer table
package ewt_pkg;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] elapsed;
        logic [3:0]  kind;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] owner;
        logic [3:0]  tier;
        logic [15:0] wait_time;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] owner;
        logic [3:0]  tier;
        logic [15:0] wait_time;
        logic [15:0] timer;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FLUSH
    } t_state;

endpackage

// ----- rtl/ewt_front.sv -----
// input stage: accepts items, drops unknown opcodes, queues commands
module ewt_front
    import ewt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_elapsed,
    input  logic [3:0]  i_work_kind,
    input  logic [7:0]  i_pos_x,
    input  logic [7:0]  i_pos_y,
    input  logic [15:0] i_owner_id,
    input  logic [3:0]  i_tier,
    input  logic [15:0] i_wait_time,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_q [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [NW-1:0] r_cnt;
    logic [NW-1:0] n_cnt;
    logic          known_op;
    logic          push;
    logic          pop;
    t_cmd          in_cmd;

    assign o_ready     = (r_cnt != NW'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    assign known_op = (i_opcode == OP_TICK) || (i_opcode == OP_CREATE)
                   || (i_opcode == OP_REMOVE);
    assign push     = i_valid && o_ready && known_op;
    assign pop      = i_cmd_pop && o_cmd_valid;

    always_comb begin
        in_cmd.op        = i_opcode;
        in_cmd.elapsed   = i_elapsed;
        in_cmd.kind      = i_work_kind;
        in_cmd.x         = i_pos_x;
        in_cmd.y         = i_pos_y;
        in_cmd.owner     = i_owner_id;
        in_cmd.tier      = i_tier;
        in_cmd.wait_time = i_wait_time;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

// ----- rtl/ewt_back.sv -----
// table engine: entry memory, create, remove and tick sweeps, result register
module ewt_back
    import ewt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_status,
    output logic [3:0]  o_done_kind,
    output logic [7:0]  o_done_x,
    output logic [7:0]  o_done_y,
    output logic [15:0] o_done_owner,
    output logic [3:0]  o_done_tier,
    output logic        o_last
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_entry        r_mem [TABLE_DEPTH];
    t_entry        r_rd;
    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] n_idx;
    logic [CW-1:0] r_keep;
    logic [CW-1:0] n_keep;
    t_cmd          r_cmd;
    t_cmd          n_cmd;
    t_entry        r_hold;
    t_entry        n_hold;
    logic          r_hold_v;
    logic          n_hold_v;
    logic          r_out_v;
    logic          n_out_v;
    logic          r_out_status;
    logic          n_out_status;
    logic [3:0]    r_out_kind;
    logic [3:0]    n_out_kind;
    logic [7:0]    r_out_x;
    logic [7:0]    n_out_x;
    logic [7:0]    r_out_y;
    logic [7:0]    n_out_y;
    logic [15:0]   r_out_owner;
    logic [15:0]   n_out_owner;
    logic [3:0]    r_out_tier;
    logic [3:0]    n_out_tier;
    logic          r_out_last;
    logic          n_out_last;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;
    t_entry        new_entry;
    logic          out_free;
    logic [16:0]   sum;
    logic [15:0]   sat_timer;
    logic          expired;
    logic          matched;
    logic          is_tick;
    logic          drop;
    logic          in_range;
    logic          step_go;
    logic [CW-1:0] idx_inc;

    assign o_valid      = r_out_v;
    assign o_status     = r_out_status;
    assign o_done_kind  = r_out_kind;
    assign o_done_x     = r_out_x;
    assign o_done_y     = r_out_y;
    assign o_done_owner = r_out_owner;
    assign o_done_tier  = r_out_tier;
    assign o_last       = r_out_last;

    assign out_free  = !r_out_v || i_ready;
    assign sum       = {1'b0, r_rd.timer} + {1'b0, r_cmd.elapsed};
    assign sat_timer = sum[16] ? 16'hFFFF : sum[15:0];
    assign expired   = (sat_timer >= r_rd.wait_time);
    assign matched   = (r_rd.x == r_cmd.x) && (r_rd.y == r_cmd.y)
                    && (r_rd.kind == r_cmd.kind);
    assign is_tick   = (r_cmd.op == OP_TICK);
    assign drop      = is_tick ? expired : matched;
    assign in_range  = (r_idx != r_count);
    assign step_go   = in_range && !(is_tick && expired && r_hold_v && !out_free);
    assign idx_inc   = r_idx + 1'b1;

    always_comb begin
        new_entry.kind      = i_cmd.kind;
        new_entry.x         = i_cmd.x;
        new_entry.y         = i_cmd.y;
        new_entry.owner     = i_cmd.owner;
        new_entry.tier      = i_cmd.tier;
        new_entry.wait_time = i_cmd.wait_time;
        new_entry.timer     = '0;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_keep       = r_keep;
        n_cmd        = r_cmd;
        n_hold       = r_hold;
        n_hold_v     = r_hold_v;
        n_out_v      = r_out_v && !i_ready;
        n_out_status = r_out_status;
        n_out_kind   = r_out_kind;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_owner  = r_out_owner;
        n_out_tier   = r_out_tier;
        n_out_last   = r_out_last;
        o_cmd_pop    = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = r_keep[IW-1:0];
        wr_data      = r_rd;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_CREATE: begin
                            if (r_count == CW'(TABLE_DEPTH)) begin
                                if (out_free) begin
                                    o_cmd_pop    = 1'b1;
                                    n_out_v      = 1'b1;
                                    n_out_status = 1'b1;
                                    n_out_kind   = '0;
                                    n_out_x      = '0;
                                    n_out_y      = '0;
                                    n_out_owner  = '0;
                                    n_out_tier   = '0;
                                    n_out_last   = 1'b1;
                                end
                            end else begin
                                o_cmd_pop = 1'b1;
                                wr_en     = 1'b1;
                                wr_addr   = r_count[IW-1:0];
                                wr_data   = new_entry;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        OP_TICK, OP_REMOVE: begin
                            o_cmd_pop = 1'b1;
                            n_cmd     = i_cmd;
                            rd_en     = (r_count != '0);
                            rd_addr   = '0;
                            n_idx     = '0;
                            n_keep    = '0;
                            n_hold_v  = 1'b0;
                            n_state   = ST_SWEEP;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                if (!in_range) begin
                    n_state = ST_FLUSH;
                end else if (step_go) begin
                    rd_en   = (idx_inc != r_count);
                    rd_addr = idx_inc[IW-1:0];
                    n_idx   = idx_inc;
                    if (drop) begin
                        if (is_tick) begin
                            if (r_hold_v) begin
                                n_out_v      = 1'b1;
                                n_out_status = 1'b0;
                                n_out_kind   = r_hold.kind;
                                n_out_x      = r_hold.x;
                                n_out_y      = r_hold.y;
                                n_out_owner  = r_hold.owner;
                                n_out_tier   = r_hold.tier;
                                n_out_last   = 1'b0;
                            end
                            n_hold   = r_rd;
                            n_hold_v = 1'b1;
                        end
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_keep[IW-1:0];
                        wr_data = r_rd;
                        if (is_tick) begin
                            wr_data.timer = sat_timer;
                        end
                        n_keep = r_keep + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_hold_v) begin
                    n_count = r_keep;
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_v      = 1'b1;
                    n_out_status = 1'b0;
                    n_out_kind   = r_hold.kind;
                    n_out_x      = r_hold.x;
                    n_out_y      = r_hold.y;
                    n_out_owner  = r_hold.owner;
                    n_out_tier   = r_hold.tier;
                    n_out_last   = 1'b1;
                    n_hold_v     = 1'b0;
                    n_count      = r_keep;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_keep   <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_keep   <= n_keep;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_hold       <= n_hold;
        r_out_status <= n_out_status;
        r_out_kind   <= n_out_kind;
        r_out_x      <= n_out_x;
        r_out_y      <= n_out_y;
        r_out_owner  <= n_out_owner;
        r_out_tier   <= n_out_tier;
        r_out_last   <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

endmodule

// ----- rtl/expiring_work_timer_table.sv -----
// top level of the expiring work timer table
// An ordered table of up to TABLE_DEPTH pending work entries. Create appends
// an entry, or returns one status result when the table is full. Remove and
// tick walk the stored entries in order through the entry memory, one entry
// per cycle while the result side does not stall; a tick result goes out one
// expired entry behind the walk so the final one can carry last. A two-command
// queue sits between the input and the table engine, and results leave through
// an output register, so items are taken while the engine is still busy.
module expiring_work_timer_table
    import ewt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_elapsed,
    input  logic [3:0]  i_work_kind,
    input  logic [7:0]  i_pos_x,
    input  logic [7:0]  i_pos_y,
    input  logic [15:0] i_owner_id,
    input  logic [3:0]  i_tier,
    input  logic [15:0] i_wait_time,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_status,
    output logic [3:0]  o_done_kind,
    output logic [7:0]  o_done_x,
    output logic [7:0]  o_done_y,
    output logic [15:0] o_done_owner,
    output logic [3:0]  o_done_tier,
    output logic        o_last
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    ewt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_elapsed   (i_elapsed),
        .i_work_kind (i_work_kind),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_owner_id  (i_owner_id),
        .i_tier      (i_tier),
        .i_wait_time (i_wait_time),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    ewt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_done_kind  (o_done_kind),
        .o_done_x     (o_done_x),
        .o_done_y     (o_done_y),
        .o_done_owner (o_done_owner),
        .o_done_tier  (o_done_tier),
        .o_last       (o_last)
    );

endmodule

// ----- rtl/ewt_checker.sv -----
// port-level assertion checker for the expiring work timer table and its bind
`include "expiring_work_timer_table_macros.svh"

module ewt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [1:0]  i_opcode,
    input logic [15:0] i_elapsed,
    input logic [3:0]  i_work_kind,
    input logic [7:0]  i_pos_x,
    input logic [7:0]  i_pos_y,
    input logic [15:0] i_owner_id,
    input logic [3:0]  i_tier,
    input logic [15:0] i_wait_time,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_status,
    input logic [3:0]  o_done_kind,
    input logic [7:0]  o_done_x,
    input logic [7:0]  o_done_y,
    input logic [15:0] o_done_owner,
    input logic [3:0]  o_done_tier,
    input logic        o_last
);

    `EWT_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_status) && $stable(o_done_kind) && $stable(o_done_x) && $stable(o_done_y) && $stable(o_done_owner) && $stable(o_done_tier) && $stable(o_last), "stalled result changed")
    `EWT_ASSERT(a_full_result, o_valid && o_status |-> o_last && o_done_kind == 4'd0 && o_done_x == 8'd0 && o_done_y == 8'd0 && o_done_owner == 16'd0 && o_done_tier == 4'd0, "table-full result malformed")
    `EWT_ASSERT(a_ready_after_reset, $rose(i_rst_n) |-> o_ready, "input not ready after reset")

endmodule

bind expiring_work_timer_table ewt_checker u_ewt_checker (.*);

// ----- tb/sv/expiring_work_timer_table_checker.sv -----
// checker for the expiring work timer table: table prediction and result comparison
`timescale 1ns / 100ps

module expiring_work_timer_table_checker
    import ewt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_elapsed,
    input  logic [3:0]  i_work_kind,
    input  logic [7:0]  i_pos_x,
    input  logic [7:0]  i_pos_y,
    input  logic [15:0] i_owner_id,
    input  logic [3:0]  i_tier,
    input  logic [15:0] i_wait_time,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_status,
    input  logic [3:0]  i_done_kind,
    input  logic [7:0]  i_done_x,
    input  logic [7:0]  i_done_y,
    input  logic [15:0] i_done_owner,
    input  logic [3:0]  i_done_tier,
    input  logic        i_last,
    input  logic        i_end,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);

    localparam logic STATUS_EXPIRED = 1'b0;
    localparam logic STATUS_FULL    = 1'b1;
    localparam int   MAX_PRINTED    = 20;

    typedef struct packed {
        logic        status;
        logic [3:0]  kind;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] owner;
        logic [3:0]  tier;
        logic        last;
    } t_work_event;

    t_entry      work_table [TABLE_DEPTH];
    int          table_fill;
    t_work_event expected_events [$];

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= MAX_PRINTED) begin
            $display("%0t ns: mismatch on result %0d: %s", $time, o_result_count, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got_v,
                               input logic [15:0] want_v);
        if (got_v !== want_v) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got_v, want_v));
        end
    endtask

    function automatic void apply_work_item(input t_cmd cmd);
        t_entry      slot;
        t_work_event ev;
        t_work_event expired [$];
        logic [16:0] sum;
        int          keep;
        keep = 0;
        case (cmd.op)
            OP_CREATE: begin
                if (table_fill >= TABLE_DEPTH) begin
                    ev = '0;
                    ev.status = STATUS_FULL;
                    ev.last = 1'b1;
                    expected_events = {expected_events, ev};
                end else begin
                    slot.kind = cmd.kind;
                    slot.x = cmd.x;
                    slot.y = cmd.y;
                    slot.owner = cmd.owner;
                    slot.tier = cmd.tier;
                    slot.wait_time = cmd.wait_time;
                    slot.timer = '0;
                    work_table[table_fill] = slot;
                    table_fill++;
                end
            end
            OP_REMOVE: begin
                for (int i = 0; i < table_fill; i++) begin
                    if (!(work_table[i].x == cmd.x && work_table[i].y == cmd.y &&
                          work_table[i].kind == cmd.kind)) begin
                        work_table[keep] = work_table[i];
                        keep++;
                    end
                end
                table_fill = keep;
            end
            OP_TICK: begin
                for (int i = 0; i < table_fill; i++) begin
                    sum = {1'b0, work_table[i].timer} + {1'b0, cmd.elapsed};
                    if (sum > 17'h0FFFF) begin
                        sum = 17'h0FFFF;
                    end
                    work_table[i].timer = sum[15:0];
                    if (sum[15:0] >= work_table[i].wait_time) begin
                        ev.status = STATUS_EXPIRED;
                        ev.kind = work_table[i].kind;
                        ev.x = work_table[i].x;
                        ev.y = work_table[i].y;
                        ev.owner = work_table[i].owner;
                        ev.tier = work_table[i].tier;
                        ev.last = 1'b0;
                        expired = {expired, ev};
                    end else begin
                        work_table[keep] = work_table[i];
                        keep++;
                    end
                end
                table_fill = keep;
                for (int j = 0; j < expired.size(); j++) begin
                    ev = expired[j];
                    ev.last = (j == expired.size() - 1);
                    expected_events = {expected_events, ev};
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic compare_event();
        t_work_event want;
        o_result_count++;
        if (expected_events.size() == 0) begin
            report_mismatch("result arrived with nothing expected");
        end else begin
            want = expected_events.pop_front();
            check_field("status", 16'(i_status), 16'(want.status));
            check_field("done_kind", 16'(i_done_kind), 16'(want.kind));
            check_field("done_x", 16'(i_done_x), 16'(want.x));
            check_field("done_y", 16'(i_done_y), 16'(want.y));
            check_field("done_owner", i_done_owner, want.owner);
            check_field("done_tier", 16'(i_done_tier), 16'(want.tier));
            check_field("last", 16'(i_last), 16'(want.last));
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_cmd seen;
        if (!i_rst_n) begin
            table_fill = 0;
            expected_events.delete();
            o_fail_count = 0;
            o_result_count = 0;
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                compare_event();
            end
            if (i_in_valid && i_in_ready) begin
                seen.op = i_opcode;
                seen.elapsed = i_elapsed;
                seen.kind = i_work_kind;
                seen.x = i_pos_x;
                seen.y = i_pos_y;
                seen.owner = i_owner_id;
                seen.tier = i_tier;
                seen.wait_time = i_wait_time;
                apply_work_item(seen);
            end
            if (i_end) begin
                while (expected_events.size() != 0) begin
                    void'(expected_events.pop_front());
                    report_mismatch("expected result never arrived");
                end
            end
            o_pending <= expected_events.size();
        end
    end

endmodule

// ----- tb/sv/expiring_work_timer_table_test.sv -----
// top of the expiring work timer table testbench: stimulus, idling and verdict
`timescale 1ns / 100ps

module expiring_work_timer_table_test;
    import ewt_pkg::*;

    localparam int         TABLE_DEPTH  = 16;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 200;
    localparam int         DRAIN_CYCLES = 80;
    localparam int         POOL_SIZE    = 4;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [1:0]  i_opcode    = '0;
    logic [15:0] i_elapsed   = '0;
    logic [3:0]  i_work_kind = '0;
    logic [7:0]  i_pos_x     = '0;
    logic [7:0]  i_pos_y     = '0;
    logic [15:0] i_owner_id  = '0;
    logic [3:0]  i_tier      = '0;
    logic [15:0] i_wait_time = '0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic        o_status;
    logic [3:0]  o_done_kind;
    logic [7:0]  o_done_x;
    logic [7:0]  o_done_y;
    logic [15:0] o_done_owner;
    logic [3:0]  o_done_tier;
    logic        o_last;
    logic        end_check   = 1'b0;

    int fail_count;
    int pending;
    int result_count;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int n_create = 0;
    int n_tick = 0;
    int n_remove = 0;
    int n_ignored = 0;

    logic [3:0] pool_kind [POOL_SIZE];
    logic [7:0] pool_x    [POOL_SIZE];
    logic [7:0] pool_y    [POOL_SIZE];

    expiring_work_timer_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_elapsed   (i_elapsed),
        .i_work_kind (i_work_kind),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_owner_id  (i_owner_id),
        .i_tier      (i_tier),
        .i_wait_time (i_wait_time),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_done_kind (o_done_kind),
        .o_done_x    (o_done_x),
        .o_done_y    (o_done_y),
        .o_done_owner(o_done_owner),
        .o_done_tier (o_done_tier),
        .o_last      (o_last)
    );

    expiring_work_timer_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) work_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_opcode      (i_opcode),
        .i_elapsed     (i_elapsed),
        .i_work_kind   (i_work_kind),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_owner_id    (i_owner_id),
        .i_tier        (i_tier),
        .i_wait_time   (i_wait_time),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_status      (o_status),
        .i_done_kind   (o_done_kind),
        .i_done_x      (o_done_x),
        .i_done_y      (o_done_y),
        .i_done_owner  (o_done_owner),
        .i_done_tier   (o_done_tier),
        .i_last        (o_last),
        .i_end         (end_check),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d results still expected", pending);
        $display("expiring_work_timer_table_test NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic t_cmd work_cmd(input logic [1:0] op, input logic [15:0] elapsed,
                                      input logic [3:0] kind, input logic [7:0] x,
                                      input logic [7:0] y, input logic [15:0] owner,
                                      input logic [3:0] tier, input logic [15:0] dur);
        t_cmd c;
        c.op = op;
        c.elapsed = elapsed;
        c.kind = kind;
        c.x = x;
        c.y = y;
        c.owner = owner;
        c.tier = tier;
        c.wait_time = dur;
        return c;
    endfunction

    // mostly keys from a small pool so removes hit, short waits so ticks expire entries
    function automatic t_cmd make_random_cmd();
        t_cmd c;
        int   pick;
        int   slot;
        pick = $urandom_range(99);
        slot = $urandom_range(POOL_SIZE - 1);
        c.kind = 4'($urandom);
        c.x = 8'($urandom);
        c.y = 8'($urandom);
        c.owner = 16'($urandom);
        c.tier = 4'($urandom);
        c.elapsed = 16'($urandom);
        c.wait_time = 16'($urandom);
        if (pick < 50) begin
            c.op = OP_CREATE;
            if ($urandom_range(99) < 70) begin
                c.kind = pool_kind[slot];
                c.x = pool_x[slot];
                c.y = pool_y[slot];
            end
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: c.wait_time = 16'($urandom_range(300));
                9: c.wait_time = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                default: begin
                end
            endcase
        end else if (pick < 80) begin
            c.op = OP_TICK;
            case ($urandom_range(19))
                17, 18, 19: c.elapsed = 16'h0000;
                14, 15, 16: begin
                end
                default: c.elapsed = 16'($urandom_range(150));
            endcase
        end else if (pick < 95) begin
            c.op = OP_REMOVE;
            if ($urandom_range(99) < 75) begin
                c.kind = pool_kind[slot];
                c.x = pool_x[slot];
                c.y = pool_y[slot];
            end
        end else begin
            c.op = OP_UNUSED;
        end
        return c;
    endfunction

    task automatic send_item(input t_cmd c);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= c.op;
        i_elapsed <= c.elapsed;
        i_work_kind <= c.kind;
        i_pos_x <= c.x;
        i_pos_y <= c.y;
        i_owner_id <= c.owner;
        i_tier <= c.tier;
        i_wait_time <= c.wait_time;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        case (c.op)
            OP_CREATE: n_create++;
            OP_TICK:   n_tick++;
            OP_REMOVE: n_remove++;
            default:   n_ignored++;
        endcase
    endtask

    // hold the sender until every expected result is back, then let the engine settle
    task automatic drain_results();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_item(work_cmd(OP_TICK, 16'd100, 4'h0, 8'h00, 8'h00, 16'h0000, 4'h0, 16'h0000));
        send_item(work_cmd(OP_CREATE, 16'h0000, 4'hF, 8'hFF, 8'hFF, 16'hFFFF, 4'hF, 16'h0000));
        send_item(work_cmd(OP_CREATE, 16'hFFFF, 4'h0, 8'h00, 8'h00, 16'h0000, 4'h0, 16'h0000));
        for (int k = 0; k < 3; k++) begin
            send_item(work_cmd(OP_CREATE, 16'h0000, 4'h2, 8'd7, 8'd9, 16'(k), 4'(k), 16'd1));
        end
        // near misses on the remove key
        send_item(work_cmd(OP_CREATE, 16'h0000, 4'h3, 8'd7, 8'd9, 16'h0A0A, 4'h1, 16'd1));
        send_item(work_cmd(OP_CREATE, 16'h0000, 4'h2, 8'd8, 8'd9, 16'h0B0B, 4'h2, 16'd1));
        send_item(work_cmd(OP_CREATE, 16'h0000, 4'h2, 8'd7, 8'd10, 16'h0C0C, 4'h3, 16'd1));
        send_item(work_cmd(OP_CREATE, 16'h0000, 4'h5, 8'd40, 8'd50, 16'h1234, 4'h5,
                           16'hFFFF));
        for (int k = 0; k < 7; k++) begin
            send_item(work_cmd(OP_CREATE, 16'h0000, 4'(k + 6), 8'(k * 30), 8'(200 - k),
                               16'(16'h8000 + k), 4'(k), 16'd30000));
        end
        // table is full now
        send_item(work_cmd(OP_CREATE, 16'h0000, 4'h9, 8'd1, 8'd2, 16'h4321, 4'h7, 16'd5));
        send_item(work_cmd(OP_REMOVE, 16'h0000, 4'h2, 8'd7, 8'd9, 16'h0000, 4'h0, 16'h0000));
        send_item(work_cmd(OP_TICK, 16'h0000, 4'h0, 8'h00, 8'h00, 16'h0000, 4'h0, 16'h0000));
        send_item(work_cmd(OP_TICK, 16'd40000, 4'h0, 8'h00, 8'h00, 16'h0000, 4'h0, 16'h0000));
        send_item(work_cmd(OP_TICK, 16'hFFFF, 4'h0, 8'h00, 8'h00, 16'h0000, 4'h0, 16'h0000));
        send_item(work_cmd(OP_UNUSED, 16'hFFFF, 4'hF, 8'hFF, 8'hFF, 16'hFFFF, 4'hF, 16'hFFFF));
    endtask

    initial begin
        t_cmd c;
        int   counted;
        counted = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_kind[k] = 4'($urandom);
            pool_x[k] = 8'($urandom);
            pool_y[k] = 8'($urandom);
        end
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 32;
                    rx_idle_pct = 69;
                end
                1: begin
                    tx_idle_pct = 69;
                    rx_idle_pct = 32;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (phase == 0) begin
                run_directed();
                drain_results();
            end
            while (counted < RANDOM_ITEMS * (phase + 1) / 3) begin
                c = make_random_cmd();
                send_item(c);
                if (c.op != OP_UNUSED) begin
                    counted++;
                end
            end
            drain_results();
        end
        end_check <= 1'b1;
        @(posedge i_clk);
        end_check <= 1'b0;
        @(posedge i_clk);
        $display("sent %0d creates, %0d ticks, %0d removes and %0d unused opcodes",
                 n_create, n_tick, n_remove, n_ignored);
        $display("checked %0d results over three idling patterns", result_count);
        if (fail_count == 0) begin
            $display("expiring_work_timer_table_test OK");
        end else begin
            $display("expiring_work_timer_table_test NOT OK");
        end
        $finish;
    end

endmodule
